// File: hw/rtl/drph_pkg.sv
package drph_pkg;

  localparam int TICK_BITS_DEF = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd10;
  localparam logic [CFG_W-1:0] PULSE_RST    = 16'd100;
  localparam logic [CFG_W-1:0] HOLDOFF_RST  = 16'd36000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_PULSE    = 2'd1,
    REG_HOLDOFF  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] settle_ticks;
    logic [CFG_W-1:0] pulse_ticks;
    logic [CFG_W-1:0] holdoff_ticks;
  } cfg_t;

  typedef struct packed {
    logic power_cut;
    logic trigger_seen;
    logic holding_off;
  } result_t;

endpackage

// File: hw/rtl/drph_core.sv
module drph_core #(
  parameter int TICK_BITS = drph_pkg::TICK_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             level,
  input  drph_pkg::cfg_t   cfg,
  output drph_pkg::result_t res
);

  localparam int CW = (TICK_BITS > drph_pkg::CFG_W) ? TICK_BITS : drph_pkg::CFG_W;

  logic [TICK_BITS-1:0] tick_count_r, tick_count_nxt;
  logic [TICK_BITS-1:0] debounce_start_r, debounce_start_nxt;
  logic [TICK_BITS-1:0] reset_start_r, reset_start_nxt;
  logic                 last_level_r, last_level_nxt;
  logic                 power_off_r, power_off_nxt;

  logic [TICK_BITS-1:0] now_inc;
  logic [TICK_BITS-1:0] el_rst;
  logic [TICK_BITS-1:0] el_db;
  logic [CW-1:0]        late_full;
  logic [TICK_BITS-1:0] late;
  logic                 rst_active;
  logic                 pulse_done;
  logic                 holdoff_done;
  logic                 seen;

  assign now_inc        = tick_count_r + 1'b1;
  assign tick_count_nxt = (now_inc == '0) ? TICK_BITS'(1) : now_inc;
  assign el_rst         = tick_count_nxt - reset_start_r;
  assign el_db          = tick_count_nxt - debounce_start_r;
  assign rst_active     = (reset_start_r != '0);
  assign pulse_done     = CW'(el_rst) >= CW'(cfg.pulse_ticks);
  assign holdoff_done   = CW'(el_rst) >= CW'(cfg.holdoff_ticks);
  assign late_full      = CW'(tick_count_nxt) - CW'(cfg.holdoff_ticks);
  assign late           = late_full[TICK_BITS-1:0];

  always_comb begin
    power_off_nxt      = power_off_r;
    last_level_nxt     = last_level_r;
    debounce_start_nxt = debounce_start_r;
    reset_start_nxt    = reset_start_r;
    seen               = 1'b0;

    if (rst_active && pulse_done) begin
      power_off_nxt = 1'b0;
    end

    if (level != last_level_r) begin
      last_level_nxt     = level;
      debounce_start_nxt = tick_count_nxt;
    end else if ((debounce_start_r != '0) &&
                 (CW'(el_db) >= CW'(cfg.settle_ticks))) begin
      debounce_start_nxt = '0;
      seen               = level;
    end

    if (!seen) begin
      if (rst_active && holdoff_done) begin
        reset_start_nxt = '0;
      end
    end else if (rst_active) begin
      // late trigger slides the window start forward, no new pulse
      if (holdoff_done) begin
        reset_start_nxt = (late == '0) ? TICK_BITS'(1) : late;
      end
    end else begin
      reset_start_nxt = tick_count_nxt;
      power_off_nxt   = 1'b1;
    end
  end

  assign res.power_cut    = power_off_nxt;
  assign res.trigger_seen = seen;
  assign res.holding_off  = (reset_start_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r     <= '0;
      debounce_start_r <= '0;
      reset_start_r    <= '0;
      last_level_r     <= 1'b0;
      power_off_r      <= 1'b0;
    end else if (step) begin
      tick_count_r     <= tick_count_nxt;
      debounce_start_r <= debounce_start_nxt;
      reset_start_r    <= reset_start_nxt;
      last_level_r     <= last_level_nxt;
      power_off_r      <= power_off_nxt;
    end
  end

endmodule

// File: hw/rtl/debounced_reset_pulse_with_holdoff.sv
// Output: the result of each accepted input transaction is registered in the output register.
// Throughput: one transaction per cycle; the input side stalls only while the
//   output register holds a result that the downstream side is stalling.
// Reset: synchronous, active low rst_n; clears tick counter, debounce and holdoff
//   state and the output valid; configuration returns to 10 / 100 / 36000 ticks.
module debounced_reset_pulse_with_holdoff #(
  parameter int TICK_BITS = drph_pkg::TICK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick channel: one transaction is one timer tick with the sampled pin level
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_trigger_level,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_power_cut,
  output logic                          out_trigger_seen,
  output logic                          out_holding_off,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [drph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drph_pkg::CFG_W-1:0]     cfg_wdata
);

  drph_pkg::cfg_t    cfg_r;
  drph_pkg::result_t res_nxt;
  drph_pkg::result_t res_r;
  logic              out_valid_r;
  logic              in_take;

  // Output register frees up when empty or when its result leaves this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers; indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks  <= drph_pkg::DEBOUNCE_RST;
      cfg_r.pulse_ticks   <= drph_pkg::PULSE_RST;
      cfg_r.holdoff_ticks <= drph_pkg::HOLDOFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        drph_pkg::REG_DEBOUNCE: cfg_r.settle_ticks  <= cfg_wdata;
        drph_pkg::REG_PULSE:    cfg_r.pulse_ticks   <= cfg_wdata;
        drph_pkg::REG_HOLDOFF:  cfg_r.holdoff_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Tick counter, debouncer and holdoff window; state advances on each transaction.
  drph_core #(
    .TICK_BITS(TICK_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_take),
    .level (in_trigger_level),
    .cfg   (cfg_r),
    .res   (res_nxt)
  );

  // Result register: valid is control, payload loads without reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power_cut    = res_r.power_cut;
  assign out_trigger_seen = res_r.trigger_seen;
  assign out_holding_off  = res_r.holding_off;

endmodule

// File: hw/rtl/drph_checker.sv
module drph_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_power_cut,
  input logic out_trigger_seen,
  input logic out_holding_off
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_power_cut) &&
    $stable(out_trigger_seen) && $stable(out_holding_off))
    else $error("stalled result changed");

  // no new transaction while the result register is blocked
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input not stalled while output blocked");

  // an accepted tick yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted tick produced no result");

  // a recognized trigger always leaves a reset or holdoff period active
  a_seen_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_seen |-> out_holding_off)
    else $error("trigger seen without holdoff");

endmodule

bind debounced_reset_pulse_with_holdoff drph_checker u_drph_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_power_cut    (out_power_cut),
  .out_trigger_seen (out_trigger_seen),
  .out_holding_off  (out_holding_off)
);
